/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define RPID_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpid check failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define RPID_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpid check failed");

`endif

/* rtl/core/rpid_pkg.sv */
// shared constants and types of the three-axis rate controller
`timescale 1ns / 1ps
package rpid_pkg;

    localparam int DT_MIN_US  = 500;
    localparam int DT_MAX_US  = 20000;

    localparam int AXES       = 3;
    localparam int TIME_W     = 48;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 20;
    localparam int LIMIT_W    = 31;
    localparam int CFG_W      = AXES * GAIN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int FLAG_W     = 2;
    localparam int FRAC_W     = 16;

    localparam int USEC_PER_S = 1000000;
    localparam int HALF_USEC  = USEC_PER_S / 2;

    // dt register holds whichever clamp bound is larger
    localparam int DT_TOP     = (DT_MIN_US > DT_MAX_US) ? DT_MIN_US : DT_MAX_US;
    localparam int DT_W       = $clog2(DT_TOP + 1);

    localparam int ERR_W      = DATA_W + 1;
    localparam int MB_W       = ((DT_W > GAIN_W) ? DT_W : GAIN_W) + 1;
    localparam int PROD_W     = ERR_W + MB_W;
    localparam int ACC_W      = PROD_W + 2;

    // |err*dt| + half a million, the numerator of the divide by one million
    localparam int NUM_W      = ERR_W + DT_W;
    localparam int INTEG_W    = NUM_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_P_GAINS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_I_GAINS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_D_GAINS        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 2'd3;

    localparam int FLAG_ENABLE = 0;
    localparam int FLAG_ARM    = 1;

    typedef struct packed {
        logic            start;
        logic            load_sp;
        logic            clear_integ;
        logic [DT_W-1:0] dt;
    } rpid_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } rpid_stat_t;

endpackage

/* rtl/core/rpid_in_if.sv */
// gyro sample channel
`timescale 1ns / 1ps
interface rpid_in_if;
    import rpid_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TIME_W-1:0]        sample_time_us;
    logic signed [DATA_W-1:0] rate_roll;
    logic signed [DATA_W-1:0] rate_pitch;
    logic signed [DATA_W-1:0] rate_yaw;
    logic signed [DATA_W-1:0] accel_roll;
    logic signed [DATA_W-1:0] accel_pitch;
    logic signed [DATA_W-1:0] accel_yaw;
    logic                     setpoint_valid;
    logic signed [DATA_W-1:0] target_roll;
    logic signed [DATA_W-1:0] target_pitch;
    logic signed [DATA_W-1:0] target_yaw;
    logic [FLAG_W-1:0]        control_flags;

    modport source (
        output valid, sample_time_us, rate_roll, rate_pitch, rate_yaw,
               accel_roll, accel_pitch, accel_yaw, setpoint_valid,
               target_roll, target_pitch, target_yaw, control_flags,
        input  ready
    );

    modport sink (
        input  valid, sample_time_us, rate_roll, rate_pitch, rate_yaw,
               accel_roll, accel_pitch, accel_yaw, setpoint_valid,
               target_roll, target_pitch, target_yaw, control_flags,
        output ready
    );
endinterface

/* rtl/core/rpid_out_if.sv */
// torque result channel
`timescale 1ns / 1ps
interface rpid_out_if;
    import rpid_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] torque_roll;
    logic signed [DATA_W-1:0] torque_pitch;
    logic signed [DATA_W-1:0] torque_yaw;

    modport source (
        output valid, torque_roll, torque_pitch, torque_yaw,
        input  ready
    );

    modport sink (
        input  valid, torque_roll, torque_pitch, torque_yaw,
        output ready
    );
endinterface

/* rtl/core/three_axis_pid_rate_controller.sv */
// top level of the three-axis pid rate controller
`timescale 1ns / 1ps
// usage:
//   sample_in carries one gyro word per sample: timestamp, body rates, angular
//   accelerations, an optional new setpoint and the enable/armed flags.
//   torque_out carries one torque word (roll, pitch, yaw) per controlled sample.
//   gains and the integrator limit are written through cfg_wr_en/cfg_index/cfg_wdata
//   while the block is idle.
//   the first sample (or any sample while the stored time is zero) and samples with
//   rate control disabled produce no word and leave the lanes idle.
//   a controlled sample passes from accept to torque_out.valid through the
//   three-step reciprocal divide by one million in each lane and the shared
//   per-lane multiplier doing dt, p, i and d products one after another; the
//   lanes take no new sample until they have handed their torque word on.
//   sample_in.ready is high whenever all three lanes are idle, so the next sample
//   is taken while a finished torque word still waits in the output register.
//   if the receiver stalls, the lanes hold their result until the output register
//   frees up, and sample_in.ready stays low in the meantime.
//   reset clears gains, limit, stored time, integrators and held setpoints.
module three_axis_pid_rate_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    rpid_in_if.sink                            sample_in,
    rpid_out_if.source                         torque_out,
    input  logic                               cfg_wr_en,
    input  logic [rpid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpid_pkg::CFG_W-1:0]         cfg_wdata
);
    import rpid_pkg::*;

    logic [CFG_W-1:0]   p_gains_reg, p_gains_next;
    logic [CFG_W-1:0]   i_gains_reg, i_gains_next;
    logic [CFG_W-1:0]   d_gains_reg, d_gains_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [TIME_W-1:0]  prev_time_reg, prev_time_next;

    logic               accept;
    logic               first;
    logic [TIME_W-1:0]  diff;
    logic [DT_W-1:0]    dt;
    rpid_cmd_t          cmd;
    logic               ack;
    logic [AXES-1:0]    lane_idle;
    logic [AXES-1:0]    lane_done;
    rpid_stat_t         lane_stat   [AXES];

    logic signed [DATA_W-1:0] rate_arr    [AXES];
    logic signed [DATA_W-1:0] accel_arr   [AXES];
    logic signed [DATA_W-1:0] target_arr  [AXES];
    logic signed [DATA_W-1:0] lane_torque [AXES];

    assign rate_arr[0]   = sample_in.rate_roll;
    assign rate_arr[1]   = sample_in.rate_pitch;
    assign rate_arr[2]   = sample_in.rate_yaw;
    assign accel_arr[0]  = sample_in.accel_roll;
    assign accel_arr[1]  = sample_in.accel_pitch;
    assign accel_arr[2]  = sample_in.accel_yaw;
    assign target_arr[0] = sample_in.target_roll;
    assign target_arr[1] = sample_in.target_pitch;
    assign target_arr[2] = sample_in.target_yaw;

    assign sample_in.ready = &lane_idle;
    assign accept          = sample_in.valid && sample_in.ready;
    assign first           = (prev_time_reg == '0);
    assign diff            = sample_in.sample_time_us - prev_time_reg;

    // min bound wins when the bounds cross
    always_comb
    begin
        if (diff < TIME_W'(DT_MIN_US))
        begin
            dt = DT_W'(DT_MIN_US);
        end
        else if (diff > TIME_W'(DT_MAX_US))
        begin
            dt = DT_W'(DT_MAX_US);
        end
        else
        begin
            dt = diff[DT_W-1:0];
        end
    end

    always_comb
    begin
        cmd.start       = accept && !first && sample_in.control_flags[FLAG_ENABLE];
        cmd.load_sp     = cmd.start && sample_in.setpoint_valid;
        cmd.clear_integ = accept && !first &&
                          (!sample_in.control_flags[FLAG_ENABLE] ||
                           !sample_in.control_flags[FLAG_ARM]);
        cmd.dt          = dt;
    end

    assign prev_time_next = accept ? sample_in.sample_time_us : prev_time_reg;

    always_comb
    begin
        p_gains_next = p_gains_reg;
        i_gains_next = i_gains_reg;
        d_gains_next = d_gains_reg;
        limit_next   = limit_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_P_GAINS:        p_gains_next = cfg_wdata;
                CFG_I_GAINS:        i_gains_next = cfg_wdata;
                CFG_D_GAINS:        d_gains_next = cfg_wdata;
                CFG_INTEGRAL_LIMIT: limit_next   = cfg_wdata[LIMIT_W-1:0];
                default:            limit_next   = limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gains_reg   <= '0;
            i_gains_reg   <= '0;
            d_gains_reg   <= '0;
            limit_reg     <= '0;
            prev_time_reg <= '0;
        end
        else
        begin
            p_gains_reg   <= p_gains_next;
            i_gains_reg   <= i_gains_next;
            d_gains_reg   <= d_gains_next;
            limit_reg     <= limit_next;
            prev_time_reg <= prev_time_next;
        end
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        rpid_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cmd),
            .rate   (rate_arr[a]),
            .accel  (accel_arr[a]),
            .target (target_arr[a]),
            .p_gain (p_gains_reg[a*GAIN_W +: GAIN_W]),
            .i_gain (i_gains_reg[a*GAIN_W +: GAIN_W]),
            .d_gain (d_gains_reg[a*GAIN_W +: GAIN_W]),
            .limit  (limit_reg),
            .ack    (ack),
            .stat   (lane_stat[a]),
            .torque (lane_torque[a])
        );
        assign lane_idle[a] = lane_stat[a].idle;
        assign lane_done[a] = lane_stat[a].done;
    end

    rpid_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lane_done   (lane_done),
        .lane_torque (lane_torque),
        .ack         (ack),
        .res         (torque_out)
    );

endmodule

/* rtl/core/rpid_div.sv */
// divide by one million: reciprocal multiply estimate, then remainder correction
`timescale 1ns / 1ps
module rpid_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rpid_pkg::NUM_W-1:0] num,
    output logic                       busy,
    output logic [rpid_pkg::NUM_W-1:0] quot
);
    import rpid_pkg::*;

    // top bits of the numerator times 2^NUM_W / 1e6, shifted back, land at most
    // two below the true quotient
    localparam int                 TOP_W   = DATA_W;
    localparam longint unsigned    RECIP   = (64'd1 << NUM_W) / 64'(USEC_PER_S);
    localparam int                 RECIP_W = $clog2(RECIP + 1);
    localparam int                 EST_W   = TOP_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
    localparam logic [NUM_W-1:0]   ONE_M   = NUM_W'(USEC_PER_S);
    localparam logic [NUM_W-1:0]   TWO_M   = NUM_W'(2 * USEC_PER_S);

    logic [2:0]         stage_reg, stage_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [RECIP_W-1:0] est_reg, est_next;
    logic [NUM_W-1:0]   back_reg, back_next;
    logic [NUM_W-1:0]   quot_reg, quot_next;

    logic [EST_W-1:0]   est_prod;
    logic [NUM_W-1:0]   rem;

    assign est_prod = num_reg[NUM_W-1 -: TOP_W] * RECIP_K;
    assign rem      = num_reg - back_reg;

    // one step per cycle: estimate, estimate times a million, correct
    always_comb
    begin
        stage_next = stage_reg << 1;
        num_next   = num_reg;
        est_next   = est_reg;
        back_next  = back_reg;
        quot_next  = quot_reg;
        if (start)
        begin
            stage_next = 3'b001;
            num_next   = num;
        end
        if (stage_reg[0])
        begin
            est_next = est_prod[EST_W-1 -: RECIP_W];
        end
        if (stage_reg[1])
        begin
            back_next = NUM_W'(est_reg) * ONE_M;
        end
        if (stage_reg[2])
        begin
            if (rem >= TWO_M)
            begin
                quot_next = NUM_W'(est_reg) + NUM_W'(2);
            end
            else if (rem >= ONE_M)
            begin
                quot_next = NUM_W'(est_reg) + NUM_W'(1);
            end
            else
            begin
                quot_next = NUM_W'(est_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        est_reg  <= est_next;
        back_reg <= back_next;
        quot_reg <= quot_next;
    end

    assign busy = |stage_reg;
    assign quot = quot_reg;

endmodule

/* rtl/core/rpid_lane.sv */
// one axis: error, clamped integrator and the three gain terms on a shared multiplier
`timescale 1ns / 1ps
module rpid_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rpid_pkg::rpid_cmd_t                 cmd,
    input  logic signed [rpid_pkg::DATA_W-1:0]  rate,
    input  logic signed [rpid_pkg::DATA_W-1:0]  accel,
    input  logic signed [rpid_pkg::DATA_W-1:0]  target,
    input  logic [rpid_pkg::GAIN_W-1:0]         p_gain,
    input  logic [rpid_pkg::GAIN_W-1:0]         i_gain,
    input  logic [rpid_pkg::GAIN_W-1:0]         d_gain,
    input  logic [rpid_pkg::LIMIT_W-1:0]        limit,
    input  logic                                ack,
    output rpid_pkg::rpid_stat_t                stat,
    output logic signed [rpid_pkg::DATA_W-1:0]  torque
);
    import rpid_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MDT   = 4'd1;
    localparam logic [3:0] ST_DIVLD = 4'd2;
    localparam logic [3:0] ST_PACC  = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_MI    = 4'd5;
    localparam logic [3:0] ST_IACC  = 4'd6;
    localparam logic [3:0] ST_DACC  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam int ROUND_HALF = 2 ** (FRAC_W - 1);

    logic [3:0]                state_reg, state_next;
    logic signed [DATA_W-1:0]  integ_reg, integ_next;
    logic signed [DATA_W-1:0]  held_reg, held_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DATA_W-1:0]  accel_reg, accel_next;
    logic [DT_W-1:0]           dt_reg, dt_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      neg_reg, neg_next;

    logic signed [ERR_W-1:0]   mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [DATA_W-1:0]  sp_eff;
    logic signed [PROD_W-1:0]  prod_mag;
    logic                      div_start;
    logic [NUM_W-1:0]          div_num;
    logic                      div_busy;
    logic [NUM_W-1:0]          div_quot;
    logic signed [INTEG_W-1:0] q_ext;
    logic signed [INTEG_W-1:0] lim_ext;
    logic signed [INTEG_W-1:0] integ_sum;
    logic signed [INTEG_W-1:0] integ_clamped;
    logic signed [ACC_W-1:0]   acc_shift;

    // shared multiplier, operands picked by the sequencer step
    always_comb
    begin
        case (state_reg)
            ST_DIVLD:
            begin
                mul_a = err_reg;
                mul_b = signed'(MB_W'(p_gain));
            end
            ST_MI:
            begin
                mul_a = ERR_W'(integ_reg);
                mul_b = signed'(MB_W'(i_gain));
            end
            ST_IACC:
            begin
                mul_a = ERR_W'(accel_reg);
                mul_b = signed'(MB_W'(d_gain));
            end
            default:
            begin
                mul_a = err_reg;
                mul_b = signed'(MB_W'(dt_reg));
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign sp_eff    = cmd.load_sp ? target : held_reg;
    assign prod_mag  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign div_num   = prod_mag[NUM_W-1:0] + NUM_W'(HALF_USEC);
    assign div_start = (state_reg == ST_DIVLD);

    rpid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // rounded increment, then symmetric clamp
    always_comb
    begin
        q_ext     = signed'(INTEG_W'(div_quot));
        lim_ext   = signed'(INTEG_W'(limit));
        integ_sum = INTEG_W'(integ_reg) + (neg_reg ? -q_ext : q_ext);
        if (integ_sum > lim_ext)
        begin
            integ_clamped = lim_ext;
        end
        else if (integ_sum < -lim_ext)
        begin
            integ_clamped = -lim_ext;
        end
        else
        begin
            integ_clamped = integ_sum;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        integ_next = integ_reg;
        held_next  = held_reg;
        err_next   = err_reg;
        accel_next = accel_reg;
        dt_next    = dt_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.clear_integ)
                begin
                    integ_next = '0;
                end
                if (cmd.load_sp)
                begin
                    held_next = target;
                end
                if (cmd.start)
                begin
                    err_next   = ERR_W'(sp_eff) - ERR_W'(rate);
                    accel_next = accel;
                    dt_next    = cmd.dt;
                    state_next = ST_MDT;
                end
            end
            ST_MDT:
            begin
                prod_next  = prod;
                state_next = ST_DIVLD;
            end
            ST_DIVLD:
            begin
                neg_next   = prod_reg[PROD_W-1];
                prod_next  = prod;
                state_next = ST_PACC;
            end
            ST_PACC:
            begin
                acc_next   = ACC_W'(prod_reg) + ACC_W'(ROUND_HALF);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    integ_next = DATA_W'(integ_clamped);
                    state_next = ST_MI;
                end
            end
            ST_MI:
            begin
                prod_next  = prod;
                state_next = ST_IACC;
            end
            ST_IACC:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                prod_next  = prod;
                state_next = ST_DACC;
            end
            ST_DACC:
            begin
                acc_next   = acc_reg - ACC_W'(prod_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            integ_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            integ_reg <= integ_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        accel_reg <= accel_next;
        dt_reg    <= dt_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
    end

    // floor the q.16 accumulator to a signed 32-bit integer and saturate
    always_comb
    begin
        acc_shift = acc_reg >>> FRAC_W;
        if ((&acc_shift[ACC_W-1:DATA_W-1]) || !(|acc_shift[ACC_W-1:DATA_W-1]))
        begin
            torque = acc_shift[DATA_W-1:0];
        end
        else if (acc_shift[ACC_W-1])
        begin
            torque = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            torque = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

endmodule

/* rtl/core/rpid_merge.sv */
// collects the three lane torques into the output register
`timescale 1ns / 1ps
module rpid_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [rpid_pkg::AXES-1:0]           lane_done,
    input  logic signed [rpid_pkg::DATA_W-1:0]  lane_torque [rpid_pkg::AXES],
    output logic                                ack,
    rpid_out_if.source                          res
);
    import rpid_pkg::*;

    logic                     valid_reg, valid_next;
    logic signed [DATA_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic                     take;

    // load when every lane is finished and the register is free or draining
    assign take = (&lane_done) && (!valid_reg || res.ready);
    assign ack  = take;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            roll_reg  <= lane_torque[0];
            pitch_reg <= lane_torque[1];
            yaw_reg   <= lane_torque[2];
        end
    end

    assign res.valid        = valid_reg;
    assign res.torque_roll  = roll_reg;
    assign res.torque_pitch = pitch_reg;
    assign res.torque_yaw   = yaw_reg;

endmodule

/* rtl/core/rpid_checker.sv */
// port-level checks of the rate controller, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rpid_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] torque_roll,
    input logic [31:0] torque_pitch,
    input logic [31:0] torque_yaw
);
    // a stalled torque word stays put
    `RPID_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(torque_roll) && $stable(torque_pitch) && $stable(torque_yaw))

    // no torque word can appear the cycle right after a sample is taken
    `RPID_ASSERT_NEXT(a_no_instant_word, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

    // a new torque word only comes out of lanes that were busy
    `RPID_ASSERT_NOW(a_word_from_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind three_axis_pid_rate_controller rpid_checker u_rpid_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_in.valid),
    .in_ready     (sample_in.ready),
    .out_valid    (torque_out.valid),
    .out_ready    (torque_out.ready),
    .torque_roll  (torque_out.torque_roll),
    .torque_pitch (torque_out.torque_pitch),
    .torque_yaw   (torque_out.torque_yaw)
);
